// File: src/ssbs_pkg.sv
package ssbs_pkg;

  // Field widths of the event and result words
  localparam int WORKER_W   = 4;
  localparam int LOSS_W     = 32;
  localparam int CLOCK_W    = 32;
  localparam int SUM_W      = 36;
  localparam int KIND_W     = 2;
  localparam int NUMW_W     = 5;
  localparam int STALE_W    = 8;
  localparam int TARGET_W   = 32;

  // Stream word layout
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USED_W = WORKER_W + CLOCK_W + SUM_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_WORKERS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALENESS        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_TARGET = 2'd2;

  localparam logic [NUMW_W-1:0]   RST_NUM_WORKERS      = 5'd16;
  localparam logic [STALE_W-1:0]  RST_STALENESS        = 8'd0;
  localparam logic [TARGET_W-1:0] RST_ITERATION_TARGET = 32'd1;

  localparam int DEF_MAX_WORKERS = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_RELEASE    = 2'd0,
    KIND_PROGRESS   = 2'd1,
    KIND_BAD_WORKER = 2'd2
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic upd_rd;
    logic upd_wr;
    logic min_run;
    logic q_start;
    logic q_clk;
    logic q_decide;
    logic self_go;
    logic prog_go;
    logic flush;
    logic err_go;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;
    logic bad_worker;
    logic scan_done;
    logic q_empty;
    logic q_more;
    logic q_release;
    logic self_release;
    logic min_changed;
    logic emit_ok;
    logic pend_valid;
  } sts_t;

endpackage

// File: src/stale_sync_barrier_scheduler_core.sv
// Events: a new event is accepted only when the controller is back in idle; the single
//   read port of the clock store, shared by the minimum sweep and the wait queue walk,
//   bounds the event rate, and output stalls lengthen an event.
// Reset: synchronous, active high; clocks, losses, queue and flags read as zero at once.
module stale_sync_barrier_scheduler_core #(
  parameter int MAX_WORKERS = ssbs_pkg::DEF_MAX_WORKERS
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration writes: 0 num_workers, 1 staleness, 2 iteration_target
  input  logic                             cfg_we,
  input  logic [ssbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Event words
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ssbs_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // worker[3:0], loss[35:4]
  // Result words
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // released_worker[3:0], progress_clock[35:4], loss_sum[71:36], finished[72]
  output logic [ssbs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [ssbs_pkg::KIND_W-1:0]      m_axis_tuser,  // kind[1:0]
  output logic                             m_axis_tlast
);
  import ssbs_pkg::*;

  // An event from an active worker steps through: clock read, clock and loss write, minimum
  // sweep, wait queue walk, self release or enqueue, progress report and final flush.
  // The datapath holds one result back so that the last word of an event carries tlast;
  // the output register lets a new event be accepted while the last word still waits.
  cmd_t cmd;
  sts_t sts;

  ssbs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  ssbs_datapath #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// File: src/ssbs_ctrl.sv
module ssbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  ssbs_pkg::sts_t   sts,
  output ssbs_pkg::cmd_t   cmd
);
  import ssbs_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_UPD_RD = 11'b000_0000_0010,
    ST_UPD_WR = 11'b000_0000_0100,
    ST_MIN    = 11'b000_0000_1000,
    ST_QSTART = 11'b000_0001_0000,
    ST_QCLK   = 11'b000_0010_0000,
    ST_QDEC   = 11'b000_0100_0000,
    ST_SELF   = 11'b000_1000_0000,
    ST_PROG   = 11'b001_0000_0000,
    ST_FLUSH  = 11'b010_0000_0000,
    ST_ERR    = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = s_axis_tvalid;
        if (s_axis_tvalid) begin
          priority if (sts.done) state_next = ST_IDLE;
          else if (sts.bad_worker) state_next = ST_ERR;
          else state_next = ST_UPD_RD;
        end
      end
      ST_UPD_RD: begin
        cmd.upd_rd = 1'b1;
        state_next = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        state_next = ST_MIN;
      end
      ST_MIN: begin
        cmd.min_run = 1'b1;
        if (sts.scan_done) state_next = ST_QSTART;
      end
      ST_QSTART: begin
        if (sts.q_empty) begin
          state_next = ST_SELF;
        end else begin
          cmd.q_start = 1'b1;
          state_next  = ST_QCLK;
        end
      end
      ST_QCLK: begin
        cmd.q_clk  = 1'b1;
        state_next = ST_QDEC;
      end
      ST_QDEC: begin
        cmd.q_decide = !sts.q_release || sts.emit_ok;
        if (cmd.q_decide) state_next = sts.q_more ? ST_QCLK : ST_SELF;
      end
      ST_SELF: begin
        cmd.self_go = !sts.self_release || sts.emit_ok;
        if (cmd.self_go) state_next = ST_PROG;
      end
      ST_PROG: begin
        cmd.prog_go = !sts.min_changed || sts.emit_ok;
        if (cmd.prog_go) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.flush = !sts.pend_valid || sts.emit_ok;
        if (cmd.flush) state_next = ST_IDLE;
      end
      ST_ERR: begin
        cmd.err_go = sts.emit_ok;
        if (cmd.err_go) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/ssbs_datapath.sv
module ssbs_datapath #(
  parameter int MAX_WORKERS = ssbs_pkg::DEF_MAX_WORKERS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ssbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [ssbs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ssbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [ssbs_pkg::KIND_W-1:0]       m_axis_tuser,
  output logic                              m_axis_tlast,
  input  ssbs_pkg::cmd_t                    cmd,
  output ssbs_pkg::sts_t                    sts
);
  import ssbs_pkg::*;

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);

  // Configuration
  logic [NUMW_W-1:0]   num_workers;
  logic [STALE_W-1:0]  staleness;
  logic [TARGET_W-1:0] iteration_target;
  logic [CNT_W-1:0]    n_act;

  // Event and scan registers
  logic [WORKER_W-1:0] w_q;
  logic [LOSS_W-1:0]   loss_q;
  logic [IDX_W-1:0]    w_idx;
  logic [CLOCK_W-1:0]  newc, newc_next;
  logic [CLOCK_W-1:0]  newmin, min_prev;
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    scan_i;
  logic                scan_issue, acc_en;
  logic                done, queued_q;

  // Stores
  logic [CLOCK_W-1:0] clk_mem  [MAX_WORKERS];
  logic [LOSS_W-1:0]  loss_mem [MAX_WORKERS];
  logic [IDX_W-1:0]   q_mem    [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] valid, waiting;
  logic [CLOCK_W-1:0] clk_rd;
  logic [LOSS_W-1:0]  loss_rd;
  logic               clk_rd_en;
  logic [IDX_W-1:0]   clk_addr;

  // Wait queue walk
  logic [CNT_W-1:0]   wait_count, q_i, q_next, kept, kept_next;
  logic [IDX_W-1:0]   q_cur, q_rd_addr, q_wr_addr, q_wr_data;
  logic               q_rd_en, q_wr_en;
  logic [CLOCK_W-1:0] q_lead;
  logic               q_release, q_more, self_release, self_append;
  logic               min_changed, fin;

  // Result staging
  logic                emit_ok, emit_new, out_load;
  logic                emit_q, emit_s, emit_p;
  kind_t               new_kind, pend_kind, out_kind;
  logic [WORKER_W-1:0] new_worker, pend_worker, out_worker;
  logic [CLOCK_W-1:0]  new_clock, pend_clock, out_clock;
  logic [SUM_W-1:0]    new_sum, pend_sum, out_sum;
  logic                pend_valid, out_valid, out_fin, out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_workers      <= RST_NUM_WORKERS;
      staleness        <= RST_STALENESS;
      iteration_target <= RST_ITERATION_TARGET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_WORKERS:      num_workers      <= cfg_data[NUMW_W-1:0];
        CFG_STALENESS:        staleness        <= cfg_data[STALE_W-1:0];
        CFG_ITERATION_TARGET: iteration_target <= cfg_data[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the worker count to 1..MAX_WORKERS
  always_comb begin
    priority if (num_workers == '0) n_act = CNT_W'(1);
    else if (32'(num_workers) > 32'(MAX_WORKERS)) n_act = CNT_W'(MAX_WORKERS);
    else n_act = CNT_W'(num_workers);
  end

  assign w_idx     = IDX_W'(w_q);
  assign newc_next = (clk_rd == '1) ? clk_rd : clk_rd + CLOCK_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      w_q    <= s_axis_tdata[WORKER_W-1:0];
      loss_q <= s_axis_tdata[WORKER_W+LOSS_W-1:WORKER_W];
    end
    if (cmd.upd_wr) begin
      newc     <= newc_next;
      queued_q <= waiting[w_idx];
    end
  end

  // Clock and loss stores; an entry never written reads as zero
  assign scan_issue = (scan_i < n_act);

  always_comb begin
    clk_rd_en = cmd.upd_rd || cmd.q_clk || (cmd.min_run && scan_issue);
    priority if (cmd.upd_rd) clk_addr = w_idx;
    else if (cmd.q_clk) clk_addr = q_cur;
    else clk_addr = scan_i[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (clk_rd_en) begin
      clk_rd <= valid[clk_addr] ? clk_mem[clk_addr] : '0;
    end
    if (cmd.min_run && scan_issue) begin
      loss_rd <= valid[scan_i[IDX_W-1:0]] ? loss_mem[scan_i[IDX_W-1:0]] : '0;
    end
    if (cmd.upd_wr) begin
      clk_mem[w_idx]  <= newc_next;
      loss_mem[w_idx] <= loss_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.upd_wr) begin
      valid[w_idx] <= 1'b1;
    end
  end

  // Minimum and loss sum sweep, accumulating each entry in the cycle after its read
  always_ff @(posedge clk) begin
    if (cmd.upd_wr) begin
      scan_i <= '0;
      acc_en <= 1'b0;
      newmin <= '1;
      sum    <= '0;
    end else if (cmd.min_run) begin
      if (scan_issue) scan_i <= scan_i + CNT_W'(1);
      acc_en <= scan_issue;
      if (acc_en) begin
        if (clk_rd < newmin) newmin <= clk_rd;
        sum <= sum + {{(SUM_W-LOSS_W){loss_rd[LOSS_W-1]}}, loss_rd};
      end
    end
  end

  // Queue decisions
  assign q_lead       = (clk_rd >= newmin) ? clk_rd - newmin : '0;
  assign q_release    = (q_lead <= CLOCK_W'(staleness));
  assign q_next       = q_i + CNT_W'(1);
  assign q_more       = (q_next < wait_count);
  assign kept_next    = q_release ? kept : kept + CNT_W'(1);
  assign self_release = !queued_q && ((newc - newmin) <= CLOCK_W'(staleness));
  assign self_append  = !queued_q && !self_release && (wait_count < CNT_W'(MAX_WORKERS));
  assign min_changed  = (newmin != min_prev);
  assign fin          = (newmin >= iteration_target);

  always_comb begin
    q_rd_en   = cmd.q_start || (cmd.q_decide && q_more);
    q_rd_addr = cmd.q_start ? '0 : q_next[IDX_W-1:0];
    q_wr_en   = (cmd.q_decide && !q_release) || (cmd.self_go && self_append);
    q_wr_addr = cmd.self_go ? wait_count[IDX_W-1:0] : kept[IDX_W-1:0];
    q_wr_data = cmd.self_go ? w_idx : q_cur;
  end

  always_ff @(posedge clk) begin
    if (q_rd_en) q_cur <= q_mem[q_rd_addr];
    if (q_wr_en) q_mem[q_wr_addr] <= q_wr_data;
    if (cmd.q_start) begin
      q_i  <= '0;
      kept <= '0;
    end else if (cmd.q_decide) begin
      q_i  <= q_next;
      kept <= kept_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_count <= '0;
      waiting    <= '0;
      min_prev   <= '0;
      done       <= 1'b0;
    end else begin
      if (cmd.q_decide) begin
        if (q_release) waiting[q_cur] <= 1'b0;
        if (!q_more) wait_count <= kept_next;
      end
      if (cmd.self_go && self_append) begin
        waiting[w_idx] <= 1'b1;
        wait_count     <= wait_count + CNT_W'(1);
      end
      if (cmd.prog_go) min_prev <= newmin;
      if (cmd.flush) done <= fin;
    end
  end

  // Hold one result back so the last of an event can be marked
  assign emit_ok  = !out_valid || m_axis_tready;
  assign emit_q   = cmd.q_decide && q_release;
  assign emit_s   = cmd.self_go && self_release;
  assign emit_p   = cmd.prog_go && min_changed;
  assign emit_new = emit_q || emit_s || emit_p;
  assign out_load = ((emit_new || cmd.flush) && pend_valid) || cmd.err_go;

  always_comb begin
    new_kind   = emit_p ? KIND_PROGRESS : KIND_RELEASE;
    new_worker = emit_q ? WORKER_W'(q_cur) : (emit_s ? w_q : '0);
    new_clock  = emit_p ? min_prev : '0;
    new_sum    = emit_p ? sum : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_new) pend_valid <= 1'b1;
      else if (cmd.flush) pend_valid <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_new) begin
      pend_kind   <= new_kind;
      pend_worker <= new_worker;
      pend_clock  <= new_clock;
      pend_sum    <= new_sum;
    end
    if (out_load) begin
      if (cmd.err_go) begin
        out_kind   <= KIND_BAD_WORKER;
        out_worker <= '0;
        out_clock  <= '0;
        out_sum    <= '0;
        out_fin    <= 1'b0;
        out_last   <= 1'b1;
      end else begin
        out_kind   <= pend_kind;
        out_worker <= pend_worker;
        out_clock  <= pend_clock;
        out_sum    <= pend_sum;
        out_fin    <= fin;
        out_last   <= cmd.flush;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W-OUT_USED_W)'(0), out_fin, out_sum, out_clock, out_worker};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

  always_comb begin
    sts              = '0;
    sts.done         = done;
    sts.bad_worker   = (32'(s_axis_tdata[WORKER_W-1:0]) >= 32'(n_act));
    sts.scan_done    = !scan_issue && !acc_en;
    sts.q_empty      = (wait_count == '0);
    sts.q_more       = q_more;
    sts.q_release    = q_release;
    sts.self_release = self_release;
    sts.min_changed  = min_changed;
    sts.emit_ok      = emit_ok;
    sts.pend_valid   = pend_valid;
  end

`ifndef NO_ASSERTIONS
  a_queue_bits: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> ($countones(waiting) == int'(wait_count)))
    else $error("waiting bits disagree with queue fill");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || m_axis_tready))
    else $error("output word overwritten before it was taken");

  a_pend_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.capture || cmd.err_go) |-> !pend_valid)
    else $error("held result left over from an earlier event");

  a_min_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.self_go |-> (newmin <= newc))
    else $error("minimum above the reporting worker's clock");
`endif

endmodule

// File: bench/stale_sync_barrier_scheduler_core_tb.sv
module stale_sync_barrier_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssbs_pkg::*;

  localparam int MAXW = DEF_MAX_WORKERS;
  // Worst event: 16 workers swept plus 16 waiters walked, plus overhead
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_EVENTS = 52;

  // One result word as the block should present it
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  worker;
    logic [31:0] clock;
    logic [35:0] sum;
    logic        fin;
    logic        last;
  } barrier_word_t;

  typedef enum logic {ROW_EVENT, ROW_CFG} row_op_t;

  // Directed stimulus row: either a register write or one completion event
  typedef struct packed {
    row_op_t                op;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [3:0]             worker;
    logic [31:0]            loss;
    logic                   bad_expected;
  } row_t;

  localparam barrier_word_t BAD_WORKER_WORD =
    '{KIND_BAD_WORKER, 4'd0, 32'd0, 36'd0, 1'b0, 1'b1};

  localparam int PLAN_LEN = 22;
  localparam row_t PLAN [PLAN_LEN] = '{
    // reset settings: sixteen workers, no staleness, target of one
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd0, 32'h7FFF_FFFF, 1'b0},
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd15, 32'h8000_0000, 1'b0},
    // worker 0 reports again while still waiting
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd0, 32'h0000_0000, 1'b0},
    '{ROW_CFG, CFG_ITERATION_TARGET, 32'hFFFF_FFFF, 4'd0, 32'h0, 1'b0},
    // zero workers acts as one
    '{ROW_CFG, CFG_NUM_WORKERS, 32'h0, 4'd0, 32'h0, 1'b0},
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd1, 32'h1234_5678, 1'b1},
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd15, 32'hFFFF_FFFF, 1'b1},
    // minimum moves: both waiters go, progress report follows
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd0, 32'hFFFF_FFFF, 1'b0},
    // above the maximum acts as sixteen, so the minimum falls back
    '{ROW_CFG, CFG_NUM_WORKERS, 32'd31, 4'd0, 32'h0, 1'b0},
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd5, 32'h0001_0000, 1'b0},
    '{ROW_CFG, CFG_STALENESS, 32'd255, 4'd0, 32'h0, 1'b0},
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd5, 32'hFFFF_0000, 1'b0},
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd9, 32'h7FFF_FFFF, 1'b0},
    // upper data bits set: only the register's own width counts
    '{ROW_CFG, CFG_NUM_WORKERS, 32'hFFFF_FFE2, 4'd0, 32'h0, 1'b0},
    '{ROW_CFG, CFG_STALENESS, 32'hFFFF_FF01, 4'd0, 32'h0, 1'b0},
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd1, 32'h8000_0000, 1'b0},
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd1, 32'h8000_0000, 1'b0},
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd1, 32'h5555_AAAA, 1'b0},
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd2, 32'hAAAA_5555, 1'b1},
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd0, 32'h0000_0001, 1'b0},
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd0, 32'hFFFF_FFFE, 1'b0},
    '{ROW_EVENT, CFG_NUM_WORKERS, 32'h0, 4'd0, 32'h8000_0001, 1'b0}
  };

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;
  logic                  m_axis_tlast;

  stale_sync_barrier_scheduler_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Barrier predictor: own copy of the registers and the scheduler state
  logic [4:0]  cfg_workers = RST_NUM_WORKERS;
  logic [7:0]  cfg_lead = RST_STALENESS;
  logic [31:0] cfg_target = RST_ITERATION_TARGET;
  logic [31:0] clock_of [MAXW] = '{default: '0};
  logic [31:0] loss_of [MAXW] = '{default: '0};
  logic [3:0]  waiters [$];
  logic [31:0] floor_clock = '0;
  logic        run_done = 1'b0;

  barrier_word_t expected_words [$];
  int          failures = 0;
  bit          steady_run = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned workers_in_use();
    if (cfg_workers == 5'd0) return 1;
    if (int'(cfg_workers) > MAXW) return MAXW;
    return int'(cfg_workers);
  endfunction

  function automatic barrier_word_t release_word(input logic [3:0] q);
    return '{KIND_RELEASE, q, 32'd0, 36'd0, 1'b0, 1'b0};
  endfunction

  // Work out every word one accepted event causes and advance the state
  function automatic void predict_event(input logic [3:0] w, input logic [31:0] loss,
                                        output barrier_word_t words [$]);
    int unsigned   n;
    int unsigned   i;
    logic [31:0]   newmin;
    logic [31:0]   lead;
    logic [35:0]   sum;
    logic [3:0]    still_waiting [$];
    bit            waiting;
    barrier_word_t word;
    words = {};
    n = workers_in_use();
    if (run_done) return;
    if (32'(w) >= n) begin
      word = '{KIND_BAD_WORKER, 4'd0, 32'd0, 36'd0, 1'b0, 1'b1};
      words = {words, word};
      return;
    end
    loss_of[w] = loss;
    if (clock_of[w] != 32'hFFFF_FFFF) clock_of[w] = clock_of[w] + 32'd1;
    newmin = 32'hFFFF_FFFF;
    for (i = 0; i < n; i++)
      if (clock_of[i] < newmin) newmin = clock_of[i];
    waiting = 1'b0;
    foreach (waiters[k])
      if (waiters[k] == w) waiting = 1'b1;
    // Walk the queue in arrival order; keep whoever still leads too far
    foreach (waiters[k]) begin
      lead = (clock_of[waiters[k]] >= newmin) ? clock_of[waiters[k]] - newmin : 32'd0;
      if (lead <= 32'(cfg_lead)) words = {words, release_word(waiters[k])};
      else still_waiting = {still_waiting, waiters[k]};
    end
    waiters = still_waiting;
    if (!waiting) begin
      if (clock_of[w] - newmin <= 32'(cfg_lead)) words = {words, release_word(w)};
      else if (waiters.size() < MAXW) waiters = {waiters, w};
    end
    if (newmin != floor_clock) begin
      sum = '0;
      for (i = 0; i < n; i++) sum = sum + {{4{loss_of[i][31]}}, loss_of[i]};
      word = '{KIND_PROGRESS, 4'd0, floor_clock, sum, 1'b0, 1'b0};
      words = {words, word};
      floor_clock = newmin;
    end
    if (floor_clock >= cfg_target) run_done = 1'b1;
    foreach (words[j]) begin
      words[j].fin = run_done;
      words[j].last = (j == words.size() - 1);
    end
  endfunction

  function automatic logic [3:0] slowest_worker();
    int unsigned i;
    int unsigned best;
    best = 0;
    for (i = 1; i < workers_in_use(); i++)
      if (clock_of[i] < clock_of[best]) best = i;
    return 4'(best);
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Register write at one edge; drop the enable on the next so that
  // back-to-back writes never touch cfg_we twice in one step
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_NUM_WORKERS:      cfg_workers = data[4:0];
      CFG_STALENESS:        cfg_lead = data[7:0];
      CFG_ITERATION_TARGET: cfg_target = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one event word, hold it until taken, then record its expectations.
  // tvalid is only lowered inside a gap, never just before it is raised again.
  task automatic push_event(input logic [3:0] w, input logic [31:0] loss,
                            input logic bad_expected);
    barrier_word_t words [$];
    if (!steady_run && $urandom_range(99) < 15)
      repeat ($urandom_range(40, 1)) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, loss, w};
    do @(posedge clk); while (!s_axis_tready);
    predict_event(w, loss, words);
    // Rows with an error code typed in trust the row, not the predictor
    if (bad_expected) expected_words = {expected_words, BAD_WORKER_WORD};
    else foreach (words[i]) expected_words = {expected_words, words[i]};
  endtask

  // Drain: stop offering, wait out every expected word, then the longest
  // event latency, since an event may still be running with nothing to say
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed traffic from active workers, a share aimed at the
  // slowest one to move the minimum, and some noise from any index
  task automatic run_random_events(input int count, input int slow_pct);
    logic [3:0]  w;
    logic [31:0] loss;
    int          r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < slow_pct) w = slowest_worker();
      else if (r < 85) w = 4'($urandom_range(workers_in_use() - 1, 0));
      else w = 4'($urandom_range(15, 0));
      case ($urandom_range(9))
        0:       loss = 32'h7FFF_FFFF;
        1:       loss = 32'h8000_0000;
        default: loss = $urandom;
      endcase
      push_event(w, loss, 1'b0);
    end
  endtask

  // Receiver: stall at random about fifteen percent of the time, none in the steady phase
  always @(posedge clk)
    m_axis_tready <= steady_run || ($urandom_range(99) >= 15);

  // Checker: compare each taken result word with the oldest expectation
  always @(posedge clk) begin
    barrier_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        failures++;
        $display("%0t: result word with no expectation waiting: kind %0d tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = expected_words.pop_front();
        compare_field("kind", 64'(want.kind), 64'(m_axis_tuser));
        compare_field("released_worker", 64'(want.worker), 64'(m_axis_tdata[3:0]));
        compare_field("progress_clock", 64'(want.clock), 64'(m_axis_tdata[35:4]));
        compare_field("loss_sum", 64'(want.sum), 64'(m_axis_tdata[71:36]));
        compare_field("finished", 64'(want.fin), 64'(m_axis_tdata[72]));
        compare_field("last", 64'(want.last), 64'(m_axis_tlast));
        compare_field("tdata padding", 64'd0, 64'(m_axis_tdata[79:73]));
      end
    end
  end

  // Watchdog: end a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int          p;
    int          guard;
    logic [4:0]  nw;
    logic [7:0]  st;
    logic [31:0] tgt;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: walk the table
    foreach (PLAN[r]) begin
      if (PLAN[r].op == ROW_CFG) begin
        settle();
        write_register(PLAN[r].idx, PLAN[r].data);
      end else begin
        push_event(PLAN[r].worker, PLAN[r].loss, PLAN[r].bad_expected);
      end
    end

    // Random phases; the target stays out of reach so the run never finishes early
    for (p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      steady_run = (p == 3);
      case ($urandom_range(7))
        0:       nw = 5'd0;
        1:       nw = 5'($urandom_range(31, 17));
        2:       nw = 5'd16;
        3:       nw = 5'($urandom_range(16, 1));
        default: nw = 5'($urandom_range(6, 1));
      endcase
      case ($urandom_range(3))
        0:       st = 8'd0;
        1:       st = 8'd255;
        2:       st = 8'($urandom_range(3, 0));
        default: st = 8'($urandom_range(255, 0));
      endcase
      tgt = ($urandom_range(3) == 0) ? {1'b1, 31'($urandom)} : 32'hFFFF_FFFF;
      write_register(CFG_NUM_WORKERS, {27'($urandom), nw});
      write_register(CFG_STALENESS, {24'($urandom), st});
      write_register(CFG_ITERATION_TARGET, tgt);
      run_random_events(PHASE_EVENTS, 15);
    end
    steady_run = 1'b0;

    // Finish phase: a near target, then events that must be ignored
    settle();
    write_register(CFG_NUM_WORKERS, 32'd3);
    write_register(CFG_STALENESS, 32'($urandom_range(2, 0)));
    write_register(CFG_ITERATION_TARGET, floor_clock + 32'd2);
    guard = 0;
    while (!run_done && guard < 300) begin
      run_random_events(1, 50);
      guard++;
    end
    run_random_events(6, 15);
    settle();
    // Lowering the target does not reopen a finished run
    write_register(CFG_ITERATION_TARGET, 32'd0);
    run_random_events(2, 15);
    settle();

    if (failures == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
